// ----- rtl/core/ssrf_pkg.sv -----
// shared constants, types and width helpers for the supersample resolve filter
package ssrf_pkg;

  localparam int CHAN_W     = 8;
  localparam int CHAN_MAX   = 255;
  localparam int SIDE_W     = 3;
  localparam int SIDE_CODES = 2 ** SIDE_W;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [ADDR_W-1:0] paddr_t;
  typedef logic [DATA_W-1:0] pdata_t;

  // register index taken from the word address bit
  typedef enum logic {
    REG_SAMPLES_PER_SIDE = 1'b0,
    REG_UNMAPPED         = 1'b1
  } reg_idx_t;

  // width of a running sum of channel*alpha over a full group
  function automatic int sum_width(input int max_side);
    return $clog2(max_side * max_side * CHAN_MAX * CHAN_MAX + 1);
  endfunction

  // width of the sample counter, able to hold the largest group size
  function automatic int count_width(input int max_side);
    return $clog2(max_side * max_side + 1);
  endfunction

endpackage

// ----- rtl/core/ssrf_accum.sv -----
// input register and per-channel multiply-accumulate with group close detection
module ssrf_accum #(
  parameter int MAX_SAMPLES_PER_SIDE = 4,
  parameter int SUM_W                = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssrf_pkg::chan_t     in_sample_red,
  input  ssrf_pkg::chan_t     in_sample_green,
  input  ssrf_pkg::chan_t     in_sample_blue,
  input  ssrf_pkg::chan_t     in_sample_alpha,
  input  ssrf_pkg::side_t     side,
  output logic                tot_valid,
  input  logic                tot_stall,
  output logic [SUM_W-1:0]    tot_red,
  output logic [SUM_W-1:0]    tot_green,
  output logic [SUM_W-1:0]    tot_blue,
  output ssrf_pkg::side_t     tot_side
);
  import ssrf_pkg::*;

  localparam int CNT_W  = count_width(MAX_SAMPLES_PER_SIDE);
  localparam int PROD_W = 2 * CHAN_W;
  localparam int GRP_W  = 2 * SIDE_W;

  logic              in_v_r;
  chan_t             red_r, green_r, blue_r, alpha_r;
  logic [SUM_W-1:0]  red_sum_r, green_sum_r, blue_sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              tot_v_r;
  logic [SUM_W-1:0]  tot_red_r, tot_green_r, tot_blue_r;
  side_t             tot_side_r;

  logic              tot_rdy;
  logic              adv;
  logic [PROD_W-1:0] red_prod, green_prod, blue_prod;
  logic [SUM_W-1:0]  red_nxt, green_nxt, blue_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [GRP_W-1:0]  group;
  logic              close;

  assign tot_rdy  = !tot_v_r || !tot_stall;
  assign adv      = in_v_r && tot_rdy;
  assign in_stall = in_v_r && !tot_rdy;

  assign red_prod   = red_r * alpha_r;
  assign green_prod = green_r * alpha_r;
  assign blue_prod  = blue_r * alpha_r;
  assign red_nxt    = red_sum_r + SUM_W'(red_prod);
  assign green_nxt  = green_sum_r + SUM_W'(green_prod);
  assign blue_nxt   = blue_sum_r + SUM_W'(blue_prod);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign group      = GRP_W'(side) * GRP_W'(side);
  // closes at the first sample that brings the count up to the group size
  assign close      = int'(cnt_inc) >= int'(group);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      cnt_r       <= '0;
      tot_v_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (tot_rdy) begin
        tot_v_r <= adv && close;
      end
      if (adv) begin
        if (close) begin
          red_sum_r   <= '0;
          green_sum_r <= '0;
          blue_sum_r  <= '0;
          cnt_r       <= '0;
        end else begin
          red_sum_r   <= red_nxt;
          green_sum_r <= green_nxt;
          blue_sum_r  <= blue_nxt;
          cnt_r       <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      red_r   <= in_sample_red;
      green_r <= in_sample_green;
      blue_r  <= in_sample_blue;
      alpha_r <= in_sample_alpha;
    end
    if (adv && close) begin
      tot_red_r   <= red_nxt;
      tot_green_r <= green_nxt;
      tot_blue_r  <= blue_nxt;
      tot_side_r  <= side;
    end
  end

  assign tot_valid = tot_v_r;
  assign tot_red   = tot_red_r;
  assign tot_green = tot_green_r;
  assign tot_blue  = tot_blue_r;
  assign tot_side  = tot_side_r;

endmodule

// ----- rtl/core/ssrf_divide.sv -----
// reciprocal-multiply division of the group sums and the result register
module ssrf_divide #(
  parameter int MAX_SAMPLES_PER_SIDE = 4,
  parameter int SUM_W                = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tot_valid,
  output logic             tot_stall,
  input  logic [SUM_W-1:0] tot_red,
  input  logic [SUM_W-1:0] tot_green,
  input  logic [SUM_W-1:0] tot_blue,
  input  ssrf_pkg::side_t  tot_side,
  output logic             out_valid,
  input  logic             out_stall,
  output ssrf_pkg::chan_t  out_pixel_red,
  output ssrf_pkg::chan_t  out_pixel_green,
  output ssrf_pkg::chan_t  out_pixel_blue
);
  import ssrf_pkg::*;

  localparam int DIV_W   = $clog2(CHAN_MAX * MAX_SAMPLES_PER_SIDE * MAX_SAMPLES_PER_SIDE);
  localparam int SH      = SUM_W + DIV_W;
  localparam int RECIP_W = SH - 7;
  localparam int MUL_W   = SUM_W + RECIP_W;
  localparam int Q_W     = MUL_W - SH;

  logic [RECIP_W-1:0] recip_tab [SIDE_CODES];
  logic [RECIP_W-1:0] recip;
  logic               out_v_r;
  chan_t              red_r, green_r, blue_r;
  logic               out_rdy;

  // ceil(2^SH / (255*s*s)) for every side code, clamped like the side itself
  for (genvar k = 0; k < SIDE_CODES; k++) begin : g_recip
    localparam int EFF = (k < 1) ? 1 :
                         ((k > MAX_SAMPLES_PER_SIDE) ? MAX_SAMPLES_PER_SIDE : k);
    localparam longint unsigned DIVISOR = longint'(CHAN_MAX * EFF * EFF);
    localparam longint unsigned RECIP   = ((64'd1 << SH) + DIVISOR - 64'd1) / DIVISOR;
    assign recip_tab[k] = RECIP_W'(RECIP);
  end

  assign recip = recip_tab[tot_side];

  function automatic chan_t resolve(input logic [SUM_W-1:0] sum,
                                    input logic [RECIP_W-1:0] m);
    logic [MUL_W-1:0] prod;
    logic [Q_W-1:0]   q;
    prod = MUL_W'(sum) * MUL_W'(m);
    q    = prod[MUL_W-1:SH];
    // only a setting change inside a group can push the average past full scale
    if (q > Q_W'(CHAN_MAX)) begin
      return chan_t'(CHAN_MAX);
    end
    return q[CHAN_W-1:0];
  endfunction

  assign out_rdy   = !out_v_r || !out_stall;
  assign tot_stall = !out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= tot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && tot_valid) begin
      red_r   <= resolve(tot_red, recip);
      green_r <= resolve(tot_green, recip);
      blue_r  <= resolve(tot_blue, recip);
    end
  end

  assign out_valid       = out_v_r;
  assign out_pixel_red   = red_r;
  assign out_pixel_green = green_r;
  assign out_pixel_blue  = blue_r;

endmodule

// ----- rtl/core/supersample_resolve_filter.sv -----
// top level of the supersample box-filter resolve with its configuration register
//
// Sub-samples of one output pixel enter on the in_ channel, S*S of them in a row,
// where S is the samples_per_side register (byte address 0). Each sample is
// weighted by its alpha and summed per colour channel; the last sample of a group
// produces one pixel on the out_ channel, each channel being sum / (255*S*S)
// truncated, premultiplied against black. Pixel alpha is implicitly opaque.
// Throughput is one sample per cycle while in_stall is low: a sample register,
// the multiply-accumulate stage and the divide/result register each take one item
// a cycle. A closed group's sums pass the total and then the result register.
// When out_stall is held, samples keep being summed behind the stalled pixel;
// in_stall only rises once a further group has closed and waits for the divider
// and one more sample sits in the sample register.
// A setting of 0 acts as 1 and values above the maximum act as the maximum.
// Reset clears the sums, the sample count and all valid flags and sets S to 1.
// The user must write the register only while no item is in flight; the block
// itself does not enforce this. A partial group keeps its sums across a write.
module supersample_resolve_filter #(
  parameter int MAX_SAMPLES_PER_SIDE = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssrf_pkg::chan_t  in_sample_red,
  input  ssrf_pkg::chan_t  in_sample_green,
  input  ssrf_pkg::chan_t  in_sample_blue,
  input  ssrf_pkg::chan_t  in_sample_alpha,
  output logic             out_valid,
  input  logic             out_stall,
  output ssrf_pkg::chan_t  out_pixel_red,
  output ssrf_pkg::chan_t  out_pixel_green,
  output ssrf_pkg::chan_t  out_pixel_blue,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  ssrf_pkg::paddr_t paddr,
  input  ssrf_pkg::pdata_t pwdata,
  output ssrf_pkg::pdata_t prdata,
  output logic             pready
);
  import ssrf_pkg::*;

  localparam int SUM_W = sum_width(MAX_SAMPLES_PER_SIDE);

  side_t            side_cfg_r;
  side_t            side_eff;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  logic             tot_valid;
  logic             tot_stall;
  logic [SUM_W-1:0] tot_red, tot_green, tot_blue;
  side_t            tot_side;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_cfg_r <= SIDE_W'(1);
    end else if (cfg_wr && (reg_idx == REG_SAMPLES_PER_SIDE)) begin
      side_cfg_r <= pwdata[SIDE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLES_PER_SIDE: prdata = DATA_W'(side_cfg_r);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    if (side_cfg_r == '0) begin
      side_eff = SIDE_W'(1);
    end else if (int'(side_cfg_r) > MAX_SAMPLES_PER_SIDE) begin
      side_eff = SIDE_W'(MAX_SAMPLES_PER_SIDE);
    end else begin
      side_eff = side_cfg_r;
    end
  end

  ssrf_accum #(
    .MAX_SAMPLES_PER_SIDE (MAX_SAMPLES_PER_SIDE),
    .SUM_W                (SUM_W)
  ) u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_red   (in_sample_red),
    .in_sample_green (in_sample_green),
    .in_sample_blue  (in_sample_blue),
    .in_sample_alpha (in_sample_alpha),
    .side            (side_eff),
    .tot_valid       (tot_valid),
    .tot_stall       (tot_stall),
    .tot_red         (tot_red),
    .tot_green       (tot_green),
    .tot_blue        (tot_blue),
    .tot_side        (tot_side)
  );

  ssrf_divide #(
    .MAX_SAMPLES_PER_SIDE (MAX_SAMPLES_PER_SIDE),
    .SUM_W                (SUM_W)
  ) u_divide (
    .clk             (clk),
    .rst_n           (rst_n),
    .tot_valid       (tot_valid),
    .tot_stall       (tot_stall),
    .tot_red         (tot_red),
    .tot_green       (tot_green),
    .tot_blue        (tot_blue),
    .tot_side        (tot_side),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue)
  );

  // input only backs up once the whole pipe is full behind a stalled result
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && tot_valid))
    else $error("input stalled with room in the pipe");

  // a closed group handed to the divider shows up as a result next cycle
  a_group_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (tot_valid && !tot_stall) |=> out_valid)
    else $error("closed group lost before the result register");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !tot_valid))
    else $error("valid flags not cleared by reset");

endmodule

// ----- tb/supersample_resolve_filter_tb.sv -----
// self-checking testbench for the supersample resolve filter
`timescale 1ns / 100ps

module supersample_resolve_filter_tb;
  import ssrf_pkg::*;

  localparam int MAX_SIDE      = 4;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int MAX_REPORTS   = 10;
  localparam longint LIMIT_NS  = 5_000_000;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } sample_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   in_valid        = 1'b0;
  logic   in_stall;
  chan_t  in_sample_red   = '0;
  chan_t  in_sample_green = '0;
  chan_t  in_sample_blue  = '0;
  chan_t  in_sample_alpha = '0;
  logic   out_valid;
  logic   out_stall       = 1'b0;
  chan_t  out_pixel_red;
  chan_t  out_pixel_green;
  chan_t  out_pixel_blue;
  logic   psel            = 1'b0;
  logic   penable         = 1'b0;
  logic   pwrite          = 1'b0;
  paddr_t paddr           = '0;
  pdata_t pwdata          = '0;
  pdata_t prdata;
  logic   pready;

  sample_t pending_samples[$];
  pixel_t  expected_pixels[$];

  // resolve state mirrored from the block
  side_t       side_setting = side_t'(1);
  int unsigned red_acc, green_acc, blue_acc;
  int unsigned samples_in_group;

  int unsigned error_count;
  int unsigned burst_left, gap_left;
  int unsigned hold_requests, hold_served, hold_left;
  int unsigned rx_cycle;
  int unsigned stall_mode;
  logic [15:0] stall_pattern;

  supersample_resolve_filter #(
    .MAX_SAMPLES_PER_SIDE(MAX_SIDE)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_red   (in_sample_red),
    .in_sample_green (in_sample_green),
    .in_sample_blue  (in_sample_blue),
    .in_sample_alpha (in_sample_alpha),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  function automatic chan_t resolve_channel_sum(int unsigned acc, int unsigned grp);
    int unsigned q;
    q = acc / (CHAN_MAX * grp);
    return (q > CHAN_MAX) ? chan_t'(CHAN_MAX) : chan_t'(q);
  endfunction

  function automatic int unsigned side_in_effect(side_t s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return s;
  endfunction

  task automatic flag_error(string what, pixel_t want, pixel_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $realtime, what,
               want.red, want.green, want.blue, got.red, got.green, got.blue);
  endtask

  // sender: bursts of items with random gaps, payload held while stalled
  always @(posedge clk) begin : sender
    sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        nxt = pending_samples.pop_front();
        in_sample_red   <= nxt.red;
        in_sample_green <= nxt.green;
        in_sample_blue  <= nxt.blue;
        in_sample_alpha <= nxt.alpha;
        in_valid        <= 1'b1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall mode changes now and then, long hold-off on request
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (rx_cycle % 97 == 0) begin
        stall_mode    = $urandom_range(0, 3);
        stall_pattern = $urandom;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= stall_pattern[rx_cycle % 16];
        endcase
      end
    end
  end

  // checks each pixel taken, then folds any sample taken into the running sums
  always @(posedge clk) begin : pixel_check
    pixel_t      got, want;
    int unsigned grp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.red   = out_pixel_red;
        got.green = out_pixel_green;
        got.blue  = out_pixel_blue;
        if (expected_pixels.size() == 0) begin
          flag_error("pixel with none expected", '0, got);
        end else begin
          want = expected_pixels.pop_front();
          if (got != want) flag_error("pixel mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        grp = side_in_effect(side_setting) * side_in_effect(side_setting);
        red_acc   += 32'(in_sample_red)   * in_sample_alpha;
        green_acc += 32'(in_sample_green) * in_sample_alpha;
        blue_acc  += 32'(in_sample_blue)  * in_sample_alpha;
        samples_in_group++;
        // group closes once the count reaches the current square, even after a change
        if (samples_in_group >= grp) begin
          want.red   = resolve_channel_sum(red_acc, grp);
          want.green = resolve_channel_sum(green_acc, grp);
          want.blue  = resolve_channel_sum(blue_acc, grp);
          expected_pixels.push_back(want);
          red_acc          = 0;
          green_acc        = 0;
          blue_acc         = 0;
          samples_in_group = 0;
        end
      end
    end
  end

  function automatic void queue_sample(chan_t r, chan_t g, chan_t b, chan_t a);
    sample_t s;
    s.red   = r;
    s.green = g;
    s.blue  = b;
    s.alpha = a;
    pending_samples.push_back(s);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s = sample_t'($urandom);
    case ($urandom_range(0, 9))
      0:       s.alpha = 8'hFF;
      1:       s.alpha = 8'h00;
      2:       s = '1;
      default: ;
    endcase
    return s;
  endfunction

  // waits for every item to be taken and every pixel to come out, then lets the pipe drain
  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_side(side_t value);
    pdata_t word;
    word = $urandom;
    word[SIDE_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= paddr_t'({REG_SAMPLES_PER_SIDE, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    side_setting = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    side_t       side_order[8];
    side_t       side;
    int unsigned grp, count, phase, sent;
    side_order = '{side_t'(1), side_t'(4), side_t'(7), side_t'(0),
                   side_t'(2), side_t'(3), side_t'(5), side_t'(6)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one sample per pixel out of reset: extremes and each colour alone
    queue_sample(8'd0,   8'd0,   8'd0,   8'd0);
    queue_sample(8'd255, 8'd255, 8'd255, 8'd255);
    queue_sample(8'd255, 8'd0,   8'd0,   8'd255);
    queue_sample(8'd0,   8'd255, 8'd0,   8'd255);
    queue_sample(8'd0,   8'd0,   8'd255, 8'd255);
    queue_sample(8'd255, 8'd255, 8'd255, 8'd0);
    queue_sample(8'd1,   8'd2,   8'd3,   8'd1);
    queue_sample(8'd200, 8'd100, 8'd50,  8'd254);
    settle();
    // zero acts as one
    write_side(side_t'(0));
    queue_sample(8'd170, 8'd85,  8'd15,  8'd128);
    queue_sample(8'd255, 8'd255, 8'd255, 8'd255);
    settle();
    write_side(side_t'(2));
    queue_sample(8'd255, 8'd0,   8'd128, 8'd255);
    queue_sample(8'd0,   8'd255, 8'd128, 8'd128);
    queue_sample(8'd17,  8'd34,  8'd51,  8'd68);
    queue_sample(8'd255, 8'd255, 8'd255, 8'd255);
    // partial group carried across a setting change, result saturates
    queue_sample(8'd255, 8'd255, 8'd255, 8'd255);
    queue_sample(8'd255, 8'd255, 8'd255, 8'd255);
    queue_sample(8'd255, 8'd200, 8'd255, 8'd255);
    settle();
    write_side(side_t'(1));
    queue_sample(8'd255, 8'd255, 8'd0,   8'd255);
    settle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      side = (phase < 8) ? side_order[phase] : side_t'($urandom_range(0, SIDE_CODES - 1));
      write_side(side);
      grp = side_in_effect(side) * side_in_effect(side);
      if (phase == 0)
        count = 300;
      else
        count = grp * $urandom_range(4, 150 / grp + 4);
      // odd tail leaves a partial group for the next setting
      if (grp > 1 && $urandom_range(0, 3) == 0)
        count += $urandom_range(1, grp - 1);
      for (int unsigned i = 0; i < count; i++)
        pending_samples.push_back(random_sample());
      // receiver holds off while the sender keeps offering items
      if (phase == 0 || $urandom_range(0, 5) == 0)
        hold_requests++;
      sent += count;
      phase++;
      settle();
    end

    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ssrf_pkg.sv
rtl/core/ssrf_accum.sv
rtl/core/ssrf_divide.sv
rtl/core/supersample_resolve_filter.sv
tb/supersample_resolve_filter_tb.sv
